// ===== src/bca_pkg.sv =====
`timescale 1ns / 1ps
package bca_pkg;

	localparam int SAMPLE_W = 12;
	localparam int AVG_W = 12;
	localparam int BRIGHT_W = 8;
	localparam int SAMPLE_MAX = 4095;

	// Brightness is 255 * average / 4096, taken from the upper bits of the product.
	localparam int BRIGHT_SCALE = 255;
	localparam int BRIGHT_SHIFT = 12;
	localparam int BPROD_W = AVG_W + BRIGHT_W;

	// Reciprocal shift that makes the share quotient exact for any window up to 64.
	localparam int DIV_SHIFT = 18;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [AVG_W-1:0] avg_t;
	typedef logic [BRIGHT_W-1:0] bright_t;

endpackage

// ===== src/boxcar_average_to_brightness.sv =====
`timescale 1ns / 1ps
// Boxcar average of converter samples with an 8-bit brightness result.
//
// The sample channel carries one 12-bit reading per transfer. The result
// channel carries the window average and the brightness derived from it,
// one result per sample, in order.
//
// A sample taken at one clock edge is in the stage-one register after it;
// its result is presented from the stage-two register once stage one
// advances. One sample is taken in every cycle while the receiver keeps up.
// The window total and the ring write are updated as the item leaves stage
// one, with a forward path for a read of the slot being written.
//
// Reset empties both stages and clears the per-entry flags of the share
// ring, so every entry reads as zero until it is first written; no clearing
// pass is needed and samples are taken right after reset.
// When the receiver stalls, the result register holds; stage one still
// takes one more sample, and sample_ready drops once both stages are full.
module boxcar_average_to_brightness
	import bca_pkg::*;
#(
	parameter int WINDOW = 50
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_ready,
	output avg_t    average,
	output bright_t brightness
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SHARE_W = $clog2(SAMPLE_MAX / WINDOW + 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

	logic [SHARE_W-1:0] share;
	logic               accept;
	logic               advance;
	logic               move;

	logic [SLOT_W-1:0]  slot_q;
	avg_t               total_q;
	logic [WINDOW-1:0]  entry_vld_q;

	logic               vld_s1;
	logic [SHARE_W-1:0] share_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [SHARE_W-1:0] rd_data_s1;
	logic               ent_vld_s1;
	logic               fwd_s1;
	logic [SHARE_W-1:0] fwd_data_s1;

	logic               vld_s2;
	avg_t               avg_s2;
	bright_t            bright_s2;

	logic [SHARE_W-1:0] ring_mem [WINDOW];

	logic [SHARE_W-1:0] old_share;
	avg_t               total_nxt;
	logic [BPROD_W-1:0] bright_prod;

	bca_share_div #(
		.WINDOW(WINDOW)
	) u_div (
		.sample(sample),
		.share (share)
	);

	assign advance = !vld_s2 || result_ready;
	assign sample_ready = !vld_s1 || advance;
	assign accept = sample_valid && sample_ready;
	assign move = vld_s1 && advance;

	assign old_share = fwd_s1 ? fwd_data_s1 : (ent_vld_s1 ? rd_data_s1 : '0);
	assign total_nxt = total_q - AVG_W'(old_share) + AVG_W'(share_s1);
	assign bright_prod = BPROD_W'(total_nxt) * BPROD_W'(BRIGHT_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			slot_q <= '0;
			total_q <= '0;
			entry_vld_q <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				vld_s2 <= vld_s1;
			end
			if (move) begin
				total_q <= total_nxt;
				entry_vld_q[slot_s1] <= 1'b1;
			end
		end
	end

	// A read of the slot that stage one writes in the same cycle takes the share directly.
	always_ff @(posedge clk) begin
		if (accept) begin
			share_s1 <= share;
			slot_s1 <= slot_q;
			ent_vld_s1 <= entry_vld_q[slot_q];
			fwd_s1 <= move && (slot_s1 == slot_q);
			fwd_data_s1 <= share_s1;
		end
		if (move) begin
			avg_s2 <= total_nxt;
			bright_s2 <= bright_prod[BRIGHT_SHIFT +: BRIGHT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			ring_mem[slot_s1] <= share_s1;
		end
		if (accept) begin
			rd_data_s1 <= ring_mem[slot_q];
		end
	end

	assign result_valid = vld_s2;
	assign average = avg_s2;
	assign brightness = bright_s2;

endmodule

// ===== src/bca_share_div.sv =====
`timescale 1ns / 1ps
module bca_share_div
	import bca_pkg::*;
#(
	parameter int WINDOW = 50
) (
	input  sample_t                                      sample,
	output logic [$clog2(SAMPLE_MAX / WINDOW + 1)-1:0]   share
);

	localparam int SHARE_W = $clog2(SAMPLE_MAX / WINDOW + 1);
	localparam int MULT_W = DIV_SHIFT + 1;
	localparam int PROD_W = SAMPLE_W + MULT_W;
	localparam logic [MULT_W-1:0] RECIP = MULT_W'(((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW);

	logic [PROD_W-1:0] prod;

	// The rounded-up reciprocal gives the truncated quotient exactly for 12-bit samples.
	assign prod = PROD_W'(sample) * PROD_W'(RECIP);
	assign share = prod[DIV_SHIFT +: SHARE_W];

endmodule

// ===== src/bca_checker.sv =====
`timescale 1ns / 1ps
module bca_checker
	import bca_pkg::*;
#(
	parameter int WINDOW = 50
) (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_ready,
	input logic    result_valid,
	input logic    result_ready,
	input avg_t    average,
	input bright_t brightness
);

	localparam avg_t AVG_BOUND = AVG_W'(WINDOW * (SAMPLE_MAX / WINDOW));

	// No result is offered in the cycle after reset is applied.
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result offered after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(average) && $stable(brightness))
		else $error("stalled result changed");

	// The average is a sum of truncated shares and never exceeds the window bound.
	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> average <= AVG_BOUND)
		else $error("average above window bound");

	a_bright: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			brightness == BRIGHT_W'((BPROD_W'(average) * BPROD_W'(BRIGHT_SCALE)) >> BRIGHT_SHIFT))
		else $error("brightness does not match average");

	// With the result side free, the block never refuses a sample.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("sample refused with empty result register");

endmodule

bind boxcar_average_to_brightness bca_checker #(.WINDOW(WINDOW)) u_bca_checker (.*);
